// File: sv/tlex_pkg.sv
// Package: payload types, lexer state codes, character constants and class functions.
package tlex_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic       last;
    } out_item_t;

    typedef enum logic [5:0] {
        ST_SEP   = 6'b000001,
        ST_TOKEN = 6'b000010,
        ST_SLASH = 6'b000100,
        ST_LINE  = 6'b001000,
        ST_BLOCK = 6'b010000,
        ST_BSTAR = 6'b100000
    } lex_state_t;

    typedef struct packed {
        lex_state_t next_state;
        logic [1:0] count;
        out_item_t  res0;
        out_item_t  res1;
    } step_t;

    localparam logic [1:0] K_CHAR = 2'd0;
    localparam logic [1:0] K_END  = 2'd1;
    localparam logic [1:0] K_ERR  = 2'd2;
    localparam logic [1:0] K_EOS  = 2'd3;

    localparam logic [1:0] MODE_WORD   = 2'd0;
    localparam logic [1:0] MODE_FNAME  = 2'd1;
    localparam logic [1:0] MODE_SINGLE = 2'd2;

    localparam logic CFG_TOKEN_MODE = 1'b0;
    localparam logic CFG_CTRL_Z     = 1'b1;

    localparam int CFG_DATA_W = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_CTRL_Z = 8'd26;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_AT     = 8'h40;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_sep(input logic [7:0] c, input logic fname);
        logic base;
        logic extra;
        base  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
                (c == CH_COMMA) || (c == CH_SEMI);
        extra = (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_EQUAL);
        return base || (!fname && extra);
    endfunction

    function automatic logic is_tok(input logic [7:0] c, input logic fname);
        logic base;
        logic extra;
        base  = is_alnum(c) || (c == CH_UNDER) || (c == CH_MINUS) || (c == CH_DOT) ||
                (c == CH_PLUS);
        extra = (c == CH_COLON) || (c == CH_BSLASH) || (c == CH_SLASH) || (c == CH_AT);
        return base || (fname && extra);
    endfunction

endpackage

// File: sv/tlex_core.sv
// Lexer next-state and result logic for one character.
module tlex_core (
    input  tlex_pkg::lex_state_t state,
    input  logic [1:0]           token_mode,
    input  logic                 ctrl_z_is_end,
    input  tlex_pkg::in_item_t   item,
    output tlex_pkg::step_t      step
);
    import tlex_pkg::*;

    function automatic out_item_t mk(input logic [1:0] k, input logic [7:0] ch,
                                     input logic lst);
        out_item_t r;
        r.kind     = k;
        r.char_out = (k == K_CHAR) ? ch : 8'd0;
        r.last     = lst;
        return r;
    endfunction

    logic [7:0] c;
    logic       eoi;
    logic       fname;
    logic       single;

    assign c      = item.char_code;
    assign eoi    = item.end_of_input || (ctrl_z_is_end && (c == CH_CTRL_Z));
    assign fname  = (token_mode == MODE_FNAME);
    assign single = (token_mode == MODE_SINGLE);

    always_comb
    begin
        step.next_state = ST_SEP;
        step.count      = 2'd0;
        step.res0       = '0;
        step.res1       = '0;
        unique case (state)
            ST_TOKEN:
            begin
                if (eoi)
                begin
                    step.count = 2'd2;
                    step.res0  = mk(K_END, 8'd0, 1'b0);
                    step.res1  = mk(K_EOS, 8'd0, 1'b1);
                end
                else if (is_sep(c, fname))
                begin
                    step.count = 2'd1;
                    step.res0  = mk(K_END, 8'd0, 1'b1);
                end
                else if (is_tok(c, fname))
                begin
                    step.count      = 2'd1;
                    step.res0       = mk(K_CHAR, c, 1'b1);
                    step.next_state = ST_TOKEN;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0  = mk(K_ERR, 8'd0, 1'b1);
                end
            end
            ST_SLASH:
            begin
                if (eoi)
                begin
                    step.count = 2'd2;
                    step.res0  = mk(K_ERR, 8'd0, 1'b0);
                    step.res1  = mk(K_EOS, 8'd0, 1'b1);
                end
                else if (c == CH_SLASH)
                begin
                    step.next_state = ST_LINE;
                end
                else if (c == CH_STAR)
                begin
                    step.next_state = ST_BLOCK;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0  = mk(K_ERR, 8'd0, 1'b1);
                end
            end
            ST_LINE:
            begin
                if (eoi)
                begin
                    step.count = 2'd1;
                    step.res0  = mk(K_EOS, 8'd0, 1'b1);
                end
                else if (c != CH_LF)
                begin
                    step.next_state = ST_LINE;
                end
            end
            ST_BLOCK, ST_BSTAR:
            begin
                if (eoi)
                begin
                    step.count = 2'd2;
                    step.res0  = mk(K_ERR, 8'd0, 1'b0);
                    step.res1  = mk(K_EOS, 8'd0, 1'b1);
                end
                else if (c == CH_STAR)
                begin
                    step.next_state = ST_BSTAR;
                end
                else if (!((state == ST_BSTAR) && (c == CH_SLASH)))
                begin
                    step.next_state = ST_BLOCK;
                end
            end
            default:
            begin
                if (eoi)
                begin
                    step.count = 2'd1;
                    step.res0  = mk(K_EOS, 8'd0, 1'b1);
                end
                else if (is_sep(c, fname))
                begin
                    step.count = 2'd0;
                end
                else if (is_tok(c, fname))
                begin
                    if (single)
                    begin
                        step.count = 2'd2;
                        step.res0  = mk(K_CHAR, c, 1'b0);
                        step.res1  = mk(K_END, 8'd0, 1'b1);
                    end
                    else
                    begin
                        step.count      = 2'd1;
                        step.res0       = mk(K_CHAR, c, 1'b1);
                        step.next_state = ST_TOKEN;
                    end
                end
                else if (c == CH_SLASH)
                begin
                    step.next_state = ST_SLASH;
                end
                else if (c == CH_HASH)
                begin
                    step.next_state = ST_LINE;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0  = mk(K_ERR, 8'd0, 1'b1);
                end
            end
        endcase
    end

endmodule

// File: sv/tlex_outq.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
module tlex_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tlex_pkg::step_t     step,
    output logic                room,
    output logic                out_valid,
    input  logic                out_stall,
    output tlex_pkg::out_item_t out_data
);
    import tlex_pkg::*;

    out_item_t         q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_plus1;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [QCNT_W-1:0] push_n;
    logic              pop;

    assign out_valid    = (count_reg != '0);
    assign out_data     = q_reg[rd_ptr_reg];
    assign pop          = out_valid && !out_stall;
    assign room         = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign push_n       = push ? QCNT_W'(step.count) : '0;
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign rd_ptr_next  = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
    assign wr_ptr_next  = wr_ptr_reg + QPTR_W'(push_n);
    assign count_next   = count_reg + push_n - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (step.count != 2'd0))
        begin
            q_reg[wr_ptr_reg] <= step.res0;
        end
        if (push && (step.count == 2'd2))
        begin
            q_reg[wr_ptr_plus1] <= step.res1;
        end
    end

endmodule

// File: sv/token_lexer_with_comments_top.sv
// Top level of the streaming token lexer with comment skipping.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  input   | in_valid, in_stall, in_data     | in
//  output  | out_valid, out_stall, out_data  | out
//  config  | cfg_we, cfg_index, cfg_data     | in
//
// A character is held in the input register, is lexed into the result queue,
// and its results are handed out from the queue head. One character per cycle
// is taken while the queue has room for two results; the output drains one result
// per cycle while out_stall is low, so that sets the rate.
// Reset puts the lexer between tokens with token_mode 0 and ctrl_z_is_end 1.
// Output stall holds the queue head and backs up into in_stall once room drops.
module token_lexer_with_comments_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tlex_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tlex_pkg::out_item_t           out_data,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [tlex_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tlex_pkg::*;

    in_item_t   item_reg;
    logic       item_vld_reg;
    logic       item_vld_next;
    lex_state_t state_reg;
    logic [1:0] token_mode_reg;
    logic       ctrl_z_reg;
    step_t      step;
    logic       room;
    logic       advance;
    logic       in_take;

    assign advance       = item_vld_reg && room;
    assign in_stall      = item_vld_reg && !advance;
    assign in_take       = in_valid && !in_stall;
    assign item_vld_next = in_take || (item_vld_reg && !advance);

    tlex_core u_core (
        .state         (state_reg),
        .token_mode    (token_mode_reg),
        .ctrl_z_is_end (ctrl_z_reg),
        .item          (item_reg),
        .step          (step)
    );

    tlex_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .step      (step),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg   <= 1'b0;
            state_reg      <= ST_SEP;
            token_mode_reg <= MODE_WORD;
            ctrl_z_reg     <= 1'b1;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            if (advance)
            begin
                state_reg <= step.next_state;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOKEN_MODE: token_mode_reg <= cfg_data;
                    CFG_CTRL_Z:     ctrl_z_reg     <= cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
    end

endmodule

// File: sv/tlex_checker.sv
// Port-level checker for the token lexer, bound to the top level.
module tlex_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input tlex_pkg::in_item_t              in_data,
    input logic                            out_valid,
    input logic                            out_stall,
    input tlex_pkg::out_item_t             out_data,
    input logic                            cfg_we,
    input logic                            cfg_index,
    input logic [tlex_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tlex_pkg::*;

    logic out_xfer;
    assign out_xfer = out_valid && !out_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output changed");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != K_CHAR) |-> (out_data.char_out == 8'd0))
        else $error("char_out nonzero on non-character result");

    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == K_EOS) |-> out_data.last)
        else $error("end of stream not marked last");

    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !out_data.last && ((out_data.kind == K_ERR) || (out_data.kind == K_END))
        |=> out_valid && (out_data.kind == K_EOS))
        else $error("first of a result pair not followed by end of stream");

    a_char_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !out_data.last && (out_data.kind == K_CHAR)
        |=> out_valid && (out_data.kind == K_END) && out_data.last)
        else $error("single-character token not followed by token end");

endmodule

bind token_lexer_with_comments_top tlex_checker u_tlex_checker (.*);
